>>> rtl/core/tsr_pkg.sv
`timescale 1ns / 1ps
package tsr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COLOUR_BITS = 8;

  // divider operands: a coordinate difference scaled by 2^FRAC_BITS over a coordinate difference
  localparam int DVS_W   = COORD_BITS + 1;
  localparam int DVD_W   = DVS_W + FRAC_BITS;
  localparam int SLOPE_W = DVD_W + 1;
  localparam int WALK_W  = COORD_BITS + FRAC_BITS + 8;
  localparam int PROD_W  = FRAC_BITS + 1 + DVS_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CNT_W   = $clog2(DVD_W);

  localparam logic [COLOUR_BITS-1:0] HELD_COLOUR_RST = COLOUR_BITS'(2);

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOWER,
    PH_UPPER
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_QDIV,
    ST_QWAIT,
    ST_MUL,
    ST_SUM,
    ST_SDIV,
    ST_SWAIT
  } seq_e;

  typedef struct packed {
    logic                    start;
    logic signed [DVD_W-1:0] dividend;
    logic signed [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SLOPE_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/tsr_if.sv
`timescale 1ns / 1ps
interface tsr_in_if import tsr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic [COLOUR_BITS-1:0]       fill_colour;

  modport source (output valid, action, ax, ay, bx, by_coord, cx, cy, fill_colour,
                  input ready);
  modport sink (input valid, action, ax, ay, bx, by_coord, cx, cy, fill_colour,
                output ready);
endinterface

interface tsr_out_if import tsr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] span_x_first;
  logic signed [COORD_BITS-1:0] span_x_second;
  logic signed [COORD_BITS-1:0] span_y;
  logic [COLOUR_BITS-1:0]       span_colour;
  logic                         span_last;

  modport source (output valid, span_x_first, span_x_second, span_y, span_colour, span_last,
                  input ready);
  modport sink (input valid, span_x_first, span_x_second, span_y, span_colour, span_last,
                output ready);
endinterface

>>> rtl/core/tsr_divider.sv
`timescale 1ns / 1ps
module tsr_divider import tsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [DVS_W:0]            rem_q, rem_d;
  logic [DVD_W-1:0]          quo_q, quo_d;
  logic [DVS_W-1:0]          dvs_q, dvs_d;
  logic                      neg_q, neg_d;
  logic                      zero_q, zero_d;
  logic signed [SLOPE_W-1:0] res_q, res_d;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVD_W-1:0] quo_step;
  logic [SLOPE_W-1:0] mag_ext;

  always_comb begin
    rem_sh   = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dvs_q};
    quo_step = {quo_q[DVD_W-2:0], ge};
    mag_ext  = SLOPE_W'(quo_step);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    res_d  = res_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[DVD_W-1] ? (~req_i.dividend + DVD_W'(1)) : req_i.dividend;
      dvs_d  = req_i.divisor[DVS_W-1] ? (~req_i.divisor + DVS_W'(1)) : req_i.divisor;
      neg_d  = req_i.dividend[DVD_W-1] ^ req_i.divisor[DVS_W-1];
      zero_d = req_i.divisor == '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = quo_step;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // a zero divisor gives a zero slope
        if (zero_q) res_d = '0;
        else        res_d = neg_q ? $signed(~mag_ext + SLOPE_W'(1)) : $signed(mag_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

>>> rtl/core/triangle_span_rasterizer.sv
`timescale 1ns / 1ps
// Advance transaction: span lands in the output register at the accepting edge,
//   one advance per cycle while the output side keeps taking spans.
// Start transaction: accepts are spaced by the passes through the one bit-per-cycle shared
//   divider, five in the general case and four with a flat edge; not ready meanwhile.
// Reset (asynchronous, active low): idle, walkers and row zero, held colour 2.
module triangle_span_rasterizer import tsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsr_in_if.sink    in_i,
  tsr_out_if.source out_o
);

  seq_e   st_q, st_d;
  phase_e phase_q, phase_d;

  logic signed [COORD_BITS-1:0] vx_q [3];
  logic signed [COORD_BITS-1:0] vy_q [3];
  logic signed [COORD_BITS-1:0] sx [3];
  logic signed [COORD_BITS-1:0] sy [3];
  logic signed [COORD_BITS-1:0] tx, ty;

  logic signed [SLOPE_W-1:0] slope_q [4];
  logic [1:0]                slot_q, slot_d;
  logic                      flat_top_q, flat_top_d;
  logic signed [FRAC_BITS:0] q_q, q_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [DVS_W-1:0]   split_q, split_d;

  logic signed [WALK_W-1:0]     walk_l_q, walk_l_d;
  logic signed [WALK_W-1:0]     walk_r_q, walk_r_d;
  logic signed [COORD_BITS-1:0] row_q, row_d;
  logic [COLOUR_BITS-1:0]       colour_q;

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] out_xl_q, out_xr_q, out_y_q;
  logic [COLOUR_BITS-1:0]       out_col_q;
  logic                         out_last_q, out_last_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept, adv_emit, slope_we;

  logic signed [DVS_W-1:0] dy21, dy31, dy32, dx31, op_dx, op_dy;
  logic signed [SUM_W-1:0] sum_s;
  logic [SUM_W-1:0]        sum_adj;
  logic [WALK_W-1:0]       wl_adj, wr_adj;
  logic signed [WALK_W-1:0] x3_walk, x1_walk;

  tsr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (st_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign adv_emit   = accept && (in_i.action == ACT_ADVANCE) && (phase_q != PH_IDLE);

  // sort by y with three compare-and-swap steps, swapping on strictly greater only
  always_comb begin
    tx = '0;
    ty = '0;
    sx[0] = in_i.ax; sy[0] = in_i.ay;
    sx[1] = in_i.bx; sy[1] = in_i.by_coord;
    sx[2] = in_i.cx; sy[2] = in_i.cy;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[0] > sy[2]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[2]; sy[0] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
  end

  always_comb begin
    dy21 = DVS_W'(vy_q[1]) - DVS_W'(vy_q[0]);
    dy31 = DVS_W'(vy_q[2]) - DVS_W'(vy_q[0]);
    dy32 = DVS_W'(vy_q[2]) - DVS_W'(vy_q[1]);
    dx31 = DVS_W'(vx_q[2]) - DVS_W'(vx_q[0]);
    case (slot_q)
      2'd0: begin op_dx = DVS_W'(vx_q[1]) - DVS_W'(vx_q[0]); op_dy = dy21; end
      2'd1: begin op_dx = split_q - DVS_W'(vx_q[0]);         op_dy = dy21; end
      2'd2: begin
        op_dx = DVS_W'(vx_q[2]) - DVS_W'(flat_top_q ? vx_q[0] : vx_q[1]);
        op_dy = dy32;
      end
      default: begin op_dx = DVS_W'(vx_q[2]) - split_q; op_dy = dy32; end
    endcase
    sum_s   = SUM_W'($signed({vx_q[0], {FRAC_BITS{1'b0}}})) + SUM_W'(prod_q);
    // truncate toward zero: bias negative sums before dropping the fraction
    sum_adj = sum_s + (sum_s[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
    x1_walk = WALK_W'($signed({vx_q[0], {FRAC_BITS{1'b0}}}));
    x3_walk = WALK_W'($signed({vx_q[2], {FRAC_BITS{1'b0}}}));
    wl_adj  = walk_l_q + (walk_l_q[WALK_W-1] ? WALK_W'((1 << FRAC_BITS) - 1) : WALK_W'(0));
    wr_adj  = walk_r_q + (walk_r_q[WALK_W-1] ? WALK_W'((1 << FRAC_BITS) - 1) : WALK_W'(0));
  end

  // sequencer
  always_comb begin
    st_d       = st_q;
    slot_d     = slot_q;
    flat_top_d = flat_top_q;
    q_d        = q_q;
    prod_d     = prod_q;
    split_d    = split_q;
    slope_we   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = $signed({op_dx, {FRAC_BITS{1'b0}}});
    div_req.divisor  = op_dy;

    unique case (st_q)
      ST_IDLE: begin
        if (accept && in_i.action == ACT_START) st_d = ST_PLAN;
      end
      ST_PLAN: begin
        slot_d     = '0;
        flat_top_d = (vy_q[0] == vy_q[1]) && (vy_q[1] != vy_q[2]);
        if (vy_q[1] == vy_q[2]) begin
          split_d = DVS_W'(vx_q[2]);
          st_d    = ST_SDIV;
        end else if (vy_q[0] == vy_q[1]) begin
          split_d = DVS_W'(vx_q[1]);
          st_d    = ST_SDIV;
        end else begin
          st_d = ST_QDIV;
        end
      end
      ST_QDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = $signed({dy21, {FRAC_BITS{1'b0}}});
        div_req.divisor  = dy31;
        st_d             = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (div_rsp.done) begin
          q_d  = div_rsp.quotient[FRAC_BITS:0];
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(q_q) * PROD_W'(dx31);
        st_d   = ST_SUM;
      end
      ST_SUM: begin
        split_d = sum_adj[FRAC_BITS +: DVS_W];
        st_d    = ST_SDIV;
      end
      ST_SDIV: begin
        div_req.start = 1'b1;
        st_d          = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (div_rsp.done) begin
          slope_we = 1'b1;
          slot_d   = slot_q + 2'd1;
          st_d     = (slot_q == 2'd3) ? ST_IDLE : ST_SDIV;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // span walkers
  always_comb begin
    phase_d     = phase_q;
    walk_l_d    = walk_l_q;
    walk_r_d    = walk_r_q;
    row_d       = row_q;
    out_last_d  = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    if (st_q == ST_PLAN) begin
      if (vy_q[0] == vy_q[1] && vy_q[1] != vy_q[2]) begin
        phase_d  = PH_UPPER;
        row_d    = vy_q[2];
        walk_l_d = x3_walk;
        walk_r_d = x3_walk;
      end else begin
        phase_d  = PH_LOWER;
        row_d    = vy_q[0];
        walk_l_d = x1_walk;
        walk_r_d = x1_walk;
      end
    end else if (accept && in_i.action == ACT_START) begin
      // drop any running triangle
      phase_d = PH_IDLE;
    end else if (adv_emit) begin
      out_valid_d = 1'b1;
      if (phase_q == PH_LOWER) begin
        if (row_q >= vy_q[1]) begin
          if (vy_q[2] > vy_q[1]) begin
            phase_d  = PH_UPPER;
            row_d    = vy_q[2];
            walk_l_d = x3_walk;
            walk_r_d = x3_walk;
          end else begin
            phase_d    = PH_IDLE;
            out_last_d = 1'b1;
          end
        end else begin
          row_d    = row_q + COORD_BITS'(1);
          walk_l_d = walk_l_q + WALK_W'(slope_q[0]);
          walk_r_d = walk_r_q + WALK_W'(slope_q[1]);
        end
      end else begin
        if (DVS_W'(row_q) <= DVS_W'(vy_q[1]) + DVS_W'(1)) begin
          phase_d    = PH_IDLE;
          out_last_d = 1'b1;
        end else begin
          row_d    = row_q - COORD_BITS'(1);
          walk_l_d = walk_l_q - WALK_W'(slope_q[2]);
          walk_r_d = walk_r_q - WALK_W'(slope_q[3]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      walk_l_q    <= '0;
      walk_r_q    <= '0;
      row_q       <= '0;
      colour_q    <= HELD_COLOUR_RST;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      split_q     <= '0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      walk_l_q    <= walk_l_d;
      walk_r_q    <= walk_r_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
      split_q     <= split_d;
      if (accept && in_i.action == ACT_START) colour_q <= in_i.fill_colour;
    end
  end

  always_ff @(posedge clk_i) begin
    flat_top_q <= flat_top_d;
    q_q        <= q_d;
    prod_q     <= prod_d;
    if (accept && in_i.action == ACT_START) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= sx[i];
        vy_q[i] <= sy[i];
      end
    end
    if (slope_we) slope_q[slot_q] <= div_rsp.quotient;
    if (adv_emit) begin
      out_xl_q   <= wl_adj[FRAC_BITS +: COORD_BITS];
      out_xr_q   <= wr_adj[FRAC_BITS +: COORD_BITS];
      out_y_q    <= row_q;
      out_col_q  <= colour_q;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.span_x_first  = out_xl_q;
  assign out_o.span_x_second = out_xr_q;
  assign out_o.span_y        = out_y_q;
  assign out_o.span_colour   = out_col_q;
  assign out_o.span_last     = out_last_q;

endmodule
